/* rtl/core/bfsp_pkg.sv */
// Package for the Bellman-Ford shortest path block: sizes, state codes and
// the control/status structs shared by the controller and the datapath.
// Depends on nothing.
package bfsp_pkg;

	localparam int MaxVertices = 32;
	localparam int MaxEdges    = 256;
	localparam int WeightBits  = 16;
	localparam int VtxBits     = 5;
	localparam int CountBits   = 6;
	localparam int EdgeAddrBits = 8;
	localparam int EdgeCntBits = 9;
	localparam int DistBits    = 21;
	localparam int EdgeWordBits = 2 * VtxBits + WeightBits;

	localparam logic [0:0] RegVertexCount = 1'b0;
	localparam logic [0:0] RegSourceVertex = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_RELAX_RD,
		ST_RELAX_EX,
		ST_CHECK_EX,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                    init_clr;   // clear vertex i
		logic [VtxBits-1:0]      vtx;        // vertex pointer
		logic                    edge_rd;    // unused; the store reads edge_addr each cycle
		logic [EdgeAddrBits-1:0] edge_addr;
		logic                    relax_apply;
		logic                    check_eval;
		logic                    clr_cycle;
	} bfsp_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic cycle_found;
	} bfsp_stat_t;

endpackage

/* rtl/core/bfsp_ram.sv */
// Generic single-port-write RAM with one registered read port.
// Depends on nothing.
module bfsp_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/core/bfsp_datapath.sv */
// Datapath: edge store, distance registers and the relax/compare unit.
// Depends on bfsp_pkg and bfsp_ram.
module bfsp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                edge_we,
	input  logic [bfsp_pkg::EdgeAddrBits-1:0]   edge_waddr,
	input  logic [bfsp_pkg::EdgeWordBits-1:0]   edge_wdata,
	input  logic [bfsp_pkg::CountBits-1:0]      n_eff,
	input  logic [bfsp_pkg::VtxBits-1:0]        source_vertex,
	input  logic                                source_ok,
	input  bfsp_pkg::bfsp_cmd_t                 cmd,
	output bfsp_pkg::bfsp_stat_t                stat,
	output logic signed [bfsp_pkg::DistBits-1:0] rd_dist,
	output logic                                rd_reach
);
	localparam int VB = bfsp_pkg::VtxBits;
	localparam int WB = bfsp_pkg::WeightBits;
	localparam int DB = bfsp_pkg::DistBits;

	logic [bfsp_pkg::EdgeWordBits-1:0] edge_word;
	logic signed [DB-1:0] dist_q [bfsp_pkg::MaxVertices];
	logic [bfsp_pkg::MaxVertices-1:0] reach_q;
	logic cycle_q;

	logic [VB-1:0] ea, eb;
	logic signed [WB-1:0] ew;
	logic signed [DB+1:0] sum, db_ext;
	logic ok, improve;
	logic signed [DB-1:0] sat;

	bfsp_ram #(.Width(bfsp_pkg::EdgeWordBits), .Depth(bfsp_pkg::MaxEdges)) u_edges (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(cmd.edge_addr), .rdata(edge_word)
	);

	// Evaluate the edge word that came out of the store
	always_comb begin
		ea = edge_word[VB-1:0];
		eb = edge_word[2*VB-1:VB];
		ew = edge_word[bfsp_pkg::EdgeWordBits-1:2*VB];
		sum = (DB+2)'(dist_q[ea]) + (DB+2)'(ew);
		db_ext = (DB+2)'(dist_q[eb]);
		ok = ({1'b0, ea} < n_eff) && ({1'b0, eb} < n_eff) && reach_q[ea];
		improve = ok && (!reach_q[eb] || (sum < db_ext));
		if (sum > (DB+2)'(2**(DB-1) - 1)) begin
			sat = DB'(2**(DB-1) - 1);
		end else if (sum < -(DB+2)'(2**(DB-1))) begin
			sat = DB'(-(2**(DB-1)));
		end else begin
			sat = sum[DB-1:0];
		end
	end

	// Distance and reach updates
	always_ff @(posedge clk) begin
		if (cmd.init_clr) begin
			dist_q[cmd.vtx] <= '0;
		end else if (cmd.relax_apply && improve) begin
			dist_q[eb] <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= '0;
			cycle_q <= 1'b0;
		end else begin
			if (cmd.init_clr) begin
				reach_q[cmd.vtx] <= source_ok && (cmd.vtx == source_vertex);
			end else if (cmd.relax_apply && improve) begin
				reach_q[eb] <= 1'b1;
			end
			if (cmd.clr_cycle) begin
				cycle_q <= 1'b0;
			end else if (cmd.check_eval && improve) begin
				cycle_q <= 1'b1;
			end
		end
	end

	assign stat.cycle_found = cycle_q;
	assign rd_reach = reach_q[cmd.vtx];
	assign rd_dist  = reach_q[cmd.vtx] ? dist_q[cmd.vtx] : '0;
endmodule

/* rtl/core/bfsp_ctrl.sv */
// Controller: load, init, relax passes, cycle check and result sequencing.
// Depends on bfsp_pkg.
module bfsp_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_fire,
	input  logic                                in_last,
	input  logic                                out_free,
	input  logic [bfsp_pkg::CountBits-1:0]      n_eff,
	input  logic [bfsp_pkg::EdgeCntBits-1:0]    edge_count,
	input  bfsp_pkg::bfsp_stat_t                stat,
	output bfsp_pkg::bfsp_cmd_t                 cmd,
	output logic                                loading,
	output logic                                run_done,
	output logic                                emit,
	output logic                                emit_last,
	output logic                                emit_cycle
);
	localparam int VB = bfsp_pkg::VtxBits;
	localparam int AB = bfsp_pkg::EdgeAddrBits;

	bfsp_pkg::state_t state_q, state_d;
	logic [VB-1:0] vtx_q, vtx_d;
	logic [AB-1:0] eaddr_q, eaddr_d;
	logic [bfsp_pkg::CountBits-1:0] pass_q, pass_d;
	logic [bfsp_pkg::EdgeCntBits-1:0] eidx;
	logic last_edge, last_vtx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfsp_pkg::ST_LOAD;
			vtx_q   <= '0;
			eaddr_q <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			vtx_q   <= vtx_d;
			eaddr_q <= eaddr_d;
			pass_q  <= pass_d;
		end
	end

	assign eidx = {1'b0, eaddr_q};
	assign last_edge = (eidx + 1'b1) >= edge_count;
	assign last_vtx = ({1'b0, vtx_q} + 1'b1) >= n_eff;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		vtx_d = vtx_q;
		eaddr_d = eaddr_q;
		pass_d = pass_q;
		cmd = '0;
		cmd.vtx = vtx_q;
		cmd.edge_addr = eaddr_q;
		loading = 1'b0;
		run_done = 1'b0;
		emit = 1'b0;
		emit_last = 1'b0;
		emit_cycle = 1'b0;
		unique case (state_q)
			bfsp_pkg::ST_LOAD: begin
				loading = 1'b1;
				if (in_fire && in_last) begin
					state_d = bfsp_pkg::ST_INIT;
					vtx_d = '0;
				end
			end
			bfsp_pkg::ST_INIT: begin
				cmd.init_clr = 1'b1;
				cmd.clr_cycle = 1'b1;
				vtx_d = vtx_q + 1'b1;
				eaddr_d = '0;
				pass_d = (bfsp_pkg::CountBits)'(1);
				if (last_vtx) begin
					vtx_d = '0;
					if (edge_count == '0) state_d = bfsp_pkg::ST_OUT;
					else if (n_eff == 1) state_d = bfsp_pkg::ST_CHECK_EX;
					else state_d = bfsp_pkg::ST_RELAX_RD;
				end
			end
			bfsp_pkg::ST_RELAX_RD: begin
				// read issued by eaddr_q; data valid next cycle
				state_d = bfsp_pkg::ST_RELAX_EX;
			end
			bfsp_pkg::ST_RELAX_EX: begin
				if (pass_q < n_eff) begin
					cmd.relax_apply = 1'b1;
				end else begin
					cmd.check_eval = 1'b1;
				end
				state_d = bfsp_pkg::ST_RELAX_RD;
				if (last_edge) begin
					eaddr_d = '0;
					if (pass_q >= n_eff) begin
						state_d = bfsp_pkg::ST_OUT;
					end
					pass_d = pass_q + 1'b1;
				end else begin
					eaddr_d = eaddr_q + 1'b1;
				end
			end
			bfsp_pkg::ST_CHECK_EX: begin
				// single-vertex graph: pass count already equals n
				pass_d = n_eff;
				eaddr_d = '0;
				state_d = bfsp_pkg::ST_RELAX_RD;
			end
			bfsp_pkg::ST_OUT: begin
				if (out_free) begin
					emit = 1'b1;
					emit_cycle = stat.cycle_found;
					emit_last = stat.cycle_found || last_vtx;
					vtx_d = vtx_q + 1'b1;
					if (emit_last) begin
						run_done = 1'b1;
						vtx_d = '0;
						state_d = bfsp_pkg::ST_LOAD;
					end
				end
			end
			default: state_d = bfsp_pkg::ST_LOAD;
		endcase
	end

	ap_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> state_q == bfsp_pkg::ST_OUT) else $error("emit outside output");
	ap_done: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |=> state_q == bfsp_pkg::ST_LOAD) else $error("run end");
	ap_apply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.relax_apply |-> !cmd.check_eval) else $error("apply and check");
endmodule

/* rtl/core/bellman_ford_shortest_paths_top.sv */
// Top level of the Bellman-Ford block: ports, config, edge loading, output register.
// Depends on bfsp_pkg, bfsp_ctrl, bfsp_datapath.
// Throughput: one edge word per cycle while loading. After the last edge: init clears
// each vertex, then n passes each read and execute every edge (n-1 relax + 1 check,
// none with no edges), then one result per cycle from a register while not stalled.
// Reset: asynchronous active low; empties edge count and flags, config to 32/0.
module bellman_ford_shortest_paths_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // edge_from[4:0], edge_to[9:5], edge_weight[25:10]
	input  logic        s_axis_tlast,  // last_edge
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // vertex_index[4:0], distance[25:5], reachable[26]
	output logic [1:0]  m_axis_tuser,  // negative_cycle[0], edge_overflow[1]
	output logic        m_axis_tlast,  // last_result
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);
	localparam int VB = bfsp_pkg::VtxBits;

	logic [bfsp_pkg::CountBits-1:0] vcount_q, n_eff;
	logic [VB-1:0] src_q;
	logic [bfsp_pkg::EdgeCntBits-1:0] ecount_q;
	logic drop_q;
	logic in_fire, out_free, keep;
	logic [VB-1:0] from, to;
	bfsp_pkg::bfsp_cmd_t cmd;
	bfsp_pkg::bfsp_stat_t stat;
	logic loading, run_done, emit, emit_last, emit_cycle;
	logic signed [bfsp_pkg::DistBits-1:0] rd_dist;
	logic rd_reach;

	assign cfg_ready = 1'b1;
	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 6'd32;
			src_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == bfsp_pkg::RegVertexCount) vcount_q <= cfg_data;
			else src_q <= cfg_data[VB-1:0];
		end
	end

	assign n_eff = (vcount_q == '0) ? 6'd1 :
		(vcount_q > 6'(bfsp_pkg::MaxVertices)) ? 6'(bfsp_pkg::MaxVertices) : vcount_q;

	assign s_axis_tready = loading;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign from = s_axis_tdata[VB-1:0];
	assign to = s_axis_tdata[2*VB-1:VB];
	assign keep = ({1'b0, from} < n_eff) && ({1'b0, to} < n_eff) &&
		(ecount_q < 9'(bfsp_pkg::MaxEdges));

	// Count stored edges and track drops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecount_q <= '0;
			drop_q <= 1'b0;
		end else if (run_done) begin
			ecount_q <= '0;
			drop_q <= 1'b0;
		end else if (in_fire) begin
			if (keep) ecount_q <= ecount_q + 1'b1;
			else drop_q <= 1'b1;
		end
	end

	assign out_free = !m_axis_tvalid || m_axis_tready;

	bfsp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_axis_tlast),
		.out_free(out_free), .n_eff(n_eff), .edge_count(ecount_q), .stat(stat),
		.cmd(cmd), .loading(loading), .run_done(run_done), .emit(emit),
		.emit_last(emit_last), .emit_cycle(emit_cycle)
	);

	bfsp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .edge_we(in_fire && keep),
		.edge_waddr(ecount_q[bfsp_pkg::EdgeAddrBits-1:0]),
		.edge_wdata(s_axis_tdata[bfsp_pkg::EdgeWordBits-1:0]),
		.n_eff(n_eff), .source_vertex(src_q), .source_ok({1'b0, src_q} < n_eff),
		.cmd(cmd), .stat(stat), .rd_dist(rd_dist), .rd_reach(rd_reach)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata <= emit_cycle ? 32'd0 :
				{5'd0, rd_reach, rd_dist, cmd.vtx};
			m_axis_tuser <= {drop_q, emit_cycle};
			m_axis_tlast <= emit_last;
		end
	end

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
	ap_noload: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !s_axis_tready) else $error("load during output");
	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		ecount_q <= 9'(bfsp_pkg::MaxEdges)) else $error("edge count overflow");
endmodule
